// ----- src/repeating_interval_timer_unit_defines.svh -----
// assertion helpers for the timer rtl
`ifndef REPEATING_INTERVAL_TIMER_UNIT_DEFINES_SVH
`define REPEATING_INTERVAL_TIMER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define RIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rit assertion failed");

// next-cycle implication, off while reset is high
`define RIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rit assertion failed");

`endif

// ----- src/rit_pkg.sv -----
`default_nettype none

package rit_pkg;

   localparam int unsigned FIELD_WIDTH     = 32;
   localparam int unsigned REQ_CODE_WIDTH  = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned REQ_DATA_WIDTH  = 64;
   localparam int unsigned RSP_DATA_WIDTH  = 104;

   // request codes
   localparam logic [REQ_CODE_WIDTH-1:0] REQ_POLL       = 3'd0;
   localparam logic [REQ_CODE_WIDTH-1:0] REQ_START      = 3'd1;
   localparam logic [REQ_CODE_WIDTH-1:0] REQ_STOP       = 3'd2;
   localparam logic [REQ_CODE_WIDTH-1:0] REQ_RESET      = 3'd3;
   localparam logic [REQ_CODE_WIDTH-1:0] REQ_SET_TARGET = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEATS  = 2'd1;

   // result fields, fired in the lowest bit
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] target_now;
      logic [FIELD_WIDTH-1:0] repeats_left;
      logic [FIELD_WIDTH-1:0] time_left;
      logic                   has_expired;
      logic                   is_running;
      logic                   fired;
   } rsp_fields_type;

   localparam int unsigned RSP_FIELDS_WIDTH = $bits(rsp_fields_type);

endpackage

`default_nettype wire

// ----- src/repeating_interval_timer_unit.sv -----
// repeating interval timer
//
// requests come in on the req_ stream: tuser carries the command (poll, start,
// stop, reset, set target), tdata carries the current time and a time value.
// every request transaction produces exactly one response transaction on the
// rsp_ stream with the fired flag, run status, time left, repeats left and
// the target after the request.
// the interval and repeats registers are written through the csr_ port while
// the block is idle; a write to repeats also reloads the repeat counter.
// the request is decoded against the timer state in the cycle it is accepted
// and the response is registered. throughput is one transaction per cycle
// while the receiver does not stall, set by the single state update path.
// when the receiver stalls, one more request is caught in a skid register and
// req_tready then drops until the output register drains.
// a synchronous reset stops the timer, clears target and saved remainder,
// zeroes both registers and empties the output and skid registers.
// all time arithmetic wraps modulo 2^TIME_WIDTH.

`default_nettype none

`include "repeating_interval_timer_unit_defines.svh"

module repeating_interval_timer_unit #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request stream
   input  wire logic                                      req_tvalid,
   output      logic                                      req_tready,
   input  wire logic [rit_pkg::REQ_DATA_WIDTH-1:0]        req_tdata,  // now_time, time_value
   input  wire logic [rit_pkg::REQ_CODE_WIDTH-1:0]        req_tuser,  // req_type
   // response stream
   output      logic                                      rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // fired, is_running, has_expired, time_left, repeats_left, target_now, zero pad
   output      logic [rit_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,
   // register write port
   input  wire logic                                      csr_we,
   input  wire logic [rit_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire logic [rit_pkg::FIELD_WIDTH-1:0]           csr_wdata
);

   typedef enum logic [1:0] {
      ST_STOPPED,
      ST_RUNNING,
      ST_EXPIRED
   } run_state_type;

   typedef logic [TIME_WIDTH-1:0] time_type;

   // configuration registers
   logic [rit_pkg::FIELD_WIDTH-1:0] interval_ff;
   logic [rit_pkg::FIELD_WIDTH-1:0] repeats_ff;

   // timer state
   run_state_type                   state_ff, state_in;
   time_type                        target_ff, target_in;
   time_type                        remainder_ff, remainder_in;
   logic [rit_pkg::FIELD_WIDTH-1:0] counter_ff, counter_in;

   // output register and skid stage
   logic                            rsp_valid_ff;
   rit_pkg::rsp_fields_type         rsp_data_ff;
   logic                            skid_valid_ff;
   rit_pkg::rsp_fields_type         skid_data_ff;

   logic                            req_accept;
   logic                            out_free;
   time_type                        now_t;
   time_type                        value_t;
   time_type                        interval_t;
   time_type                        since_target;   // now - target, top bit set means not reached
   time_type                        left;
   logic                            fired;
   rit_pkg::rsp_fields_type         result;

   assign req_tready = ~skid_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign now_t      = TIME_WIDTH'(req_tdata[rit_pkg::FIELD_WIDTH-1:0]);
   assign value_t    = TIME_WIDTH'(req_tdata[rit_pkg::REQ_DATA_WIDTH-1:rit_pkg::FIELD_WIDTH]);
   assign interval_t = TIME_WIDTH'(interval_ff);
   assign since_target = now_t - target_ff;

   // command decode against the current state
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      remainder_in = remainder_ff;
      counter_in   = counter_ff;
      fired        = 1'b0;
      unique case (req_tuser)
         rit_pkg::REQ_POLL: begin
            if (state_ff == ST_RUNNING && !since_target[TIME_WIDTH-1]) begin
               fired = 1'b1;
               if (counter_ff != rit_pkg::FIELD_WIDTH'(1)) begin
                  // zero means repeat forever, so it never counts down
                  if (counter_ff != '0) begin
                     counter_in = counter_ff - rit_pkg::FIELD_WIDTH'(1);
                  end
                  target_in = target_ff + interval_t;
               end else begin
                  state_in = ST_EXPIRED;
               end
            end
         end
         rit_pkg::REQ_START: begin
            state_in = ST_RUNNING;
            // resume from a stop that left time on the clock
            if (remainder_ff != '0) begin
               target_in    = value_t + remainder_ff;
               remainder_in = '0;
            end else begin
               target_in = value_t + interval_t;
            end
         end
         rit_pkg::REQ_STOP: begin
            state_in = ST_STOPPED;
            if (since_target[TIME_WIDTH-1]) begin
               remainder_in = target_ff - now_t;
            end
         end
         rit_pkg::REQ_RESET: begin
            state_in     = ST_STOPPED;
            remainder_in = '0;
            counter_in   = repeats_ff;
         end
         rit_pkg::REQ_SET_TARGET: begin
            target_in = value_t;
         end
         default: begin
         end
      endcase
   end

   // status after the request
   always_comb begin
      if (state_in == ST_RUNNING) begin
         left = target_in - now_t;
      end else begin
         left = remainder_in;
      end
      result.fired       = fired;
      result.is_running  = (state_in == ST_RUNNING);
      result.has_expired = (state_in == ST_EXPIRED);
      result.time_left   = rit_pkg::FIELD_WIDTH'(left);
      // the final repeat reads as none left
      if (state_in == ST_EXPIRED && counter_in == rit_pkg::FIELD_WIDTH'(1)) begin
         result.repeats_left = '0;
      end else begin
         result.repeats_left = counter_in;
      end
      result.target_now  = rit_pkg::FIELD_WIDTH'(target_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= '0;
         repeats_ff    <= '0;
         state_ff      <= ST_STOPPED;
         target_ff     <= '0;
         remainder_ff  <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            target_ff    <= target_in;
            remainder_ff <= remainder_in;
            counter_ff   <= counter_in;
         end

         // only to be taken while idle: the user must keep to this, the block itself does not enforce it
         if (csr_we) begin
            unique case (csr_index)
               rit_pkg::CSR_INTERVAL: begin
                  interval_ff <= csr_wdata;
               end
               rit_pkg::CSR_REPEATS: begin
                  repeats_ff <= csr_wdata;
                  counter_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end

         // output register fed from the skid stage first, then the new result
         if (out_free) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               rsp_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end else if (req_accept) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= result;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= result;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rit_pkg::RSP_DATA_WIDTH - rit_pkg::RSP_FIELDS_WIDTH)'(0), rsp_data_ff};

   // skid stage only fills behind a stalled output
   `RIT_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // a firing is only reported by a timer that is running or just expired
   `RIT_ASSERT_NOW(a_fired_status, clock, reset, rsp_valid_ff && rsp_data_ff.fired,
      rsp_data_ff.is_running || rsp_data_ff.has_expired)
   // running and expired are never reported together
   `RIT_ASSERT_NOW(a_status_excl, clock, reset, rsp_valid_ff,
      !(rsp_data_ff.is_running && rsp_data_ff.has_expired))
   // expiry holds until a start, stop or reset command
   `RIT_ASSERT_NEXT(a_expired_sticky, clock, reset,
      state_ff == ST_EXPIRED && !(req_accept &&
         (req_tuser == rit_pkg::REQ_START || req_tuser == rit_pkg::REQ_STOP ||
          req_tuser == rit_pkg::REQ_RESET)),
      state_ff == ST_EXPIRED)

endmodule

`default_nettype wire
